>>> rtl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// Bounded deque package
// Shared sizes, codes, the command type and ring index arithmetic.
// ----------------------------------------------------------------------------
package bdq_pkg;

  // Store geometry and field widths.
  localparam int DEPTH     = 16;
  localparam int KEY_WIDTH = 32;
  localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int POS_W     = 4;
  localparam int MODE_W    = 3;
  localparam int STATUS_W  = 2;

  // Command queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Operation codes as they arrive on the mode field.
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_BACK   = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_SEARCH     = 3'd4,
    MODE_DUMP       = 3'd5
  } mode_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SEARCH,
    S_DUMP
  } back_state_e;

  // One classified command as it travels through the queue.
  typedef struct packed {
    mode_e                        op;
    logic signed [KEY_WIDTH-1:0]  key;
  } cmd_t;

  // Ring index of base plus offset, both below DEPTH.
  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                 input logic [PTR_W-1:0] off);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (PTR_W + 1)'(DEPTH)) begin
      sum = sum - (PTR_W + 1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  // Position field from an entry offset.
  function automatic logic [POS_W-1:0] pos_of(input logic [CNT_W-1:0] v);
    return POS_W'(v);
  endfunction

endpackage

>>> rtl/bdq_in_if.sv
// ----------------------------------------------------------------------------
// Deque input channel
// Valid/ready channel that carries one operation item.
// ----------------------------------------------------------------------------
interface bdq_in_if
  import bdq_pkg::*;
();
  logic                        valid;
  logic                        ready;
  logic [MODE_W-1:0]           mode;
  logic signed [KEY_WIDTH-1:0] key_in;

  modport source (output valid, output mode, output key_in, input ready);
  modport sink   (input valid, input mode, input key_in, output ready);
endinterface

>>> rtl/bdq_out_if.sv
// ----------------------------------------------------------------------------
// Deque output channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
interface bdq_out_if
  import bdq_pkg::*;
();
  logic                        valid;
  logic                        ready;
  logic signed [KEY_WIDTH-1:0] key_out;
  logic [POS_W-1:0]            position;
  logic [STATUS_W-1:0]         status;
  logic                        last;

  modport source (output valid, output key_out, output position, output status,
                  output last, input ready);
  modport sink   (input valid, input key_out, input position, input status,
                  input last, output ready);
endinterface

>>> rtl/bdq_front.sv
// ----------------------------------------------------------------------------
// Deque front end
// Accepts operation items, decodes the mode and forwards valid commands.
// ----------------------------------------------------------------------------
module bdq_front
  import bdq_pkg::*;
(
  bdq_in_if.sink  in_i,
  output logic    cmd_valid_o,
  output cmd_t    cmd_o,
  input  logic    cmd_ready_i
);

  logic mode_known;

  // Unused mode codes are taken and dropped without a command.
  assign mode_known  = (in_i.mode <= MODE_W'(MODE_DUMP));
  assign in_i.ready  = cmd_ready_i;
  assign cmd_valid_o = in_i.valid && mode_known;
  assign cmd_o.op    = mode_e'(in_i.mode);
  assign cmd_o.key   = in_i.key_in;

endmodule

>>> rtl/bdq_cmd_queue.sv
// ----------------------------------------------------------------------------
// Deque command queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module bdq_cmd_queue
  import bdq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  cmd_t in_cmd_i,
  output logic in_ready_o,
  output logic out_valid_o,
  output cmd_t out_cmd_o,
  input  logic out_ready_i
);

  cmd_t              slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_wr, do_rd;

  assign in_ready_o  = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign out_cmd_o   = slots_q[rd_ptr_q];
  assign do_wr       = in_valid_i && in_ready_o;
  assign do_rd       = out_valid_o && out_ready_i;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_wr && do_rd) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Slot storage.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slots_q[wr_ptr_q] <= in_cmd_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("command queue fill count out of range");

endmodule

>>> rtl/bdq_back.sv
// ----------------------------------------------------------------------------
// Deque back end
// Key ring, head pointer, entry count, walk sequencer and result register.
// ----------------------------------------------------------------------------
module bdq_back
  import bdq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_ready_o,
  bdq_out_if.source out_o
);

  // Key ring memory with a registered read port.
  logic signed [KEY_WIDTH-1:0] mem [DEPTH];
  logic signed [KEY_WIDTH-1:0] rdata_q;
  logic                        we, re;
  logic [PTR_W-1:0]            waddr, raddr;

  back_state_e                 state_q, state_d;
  logic [PTR_W-1:0]            front_q, front_d;
  logic [CNT_W-1:0]            count_q, count_d;
  logic [CNT_W-1:0]            idx_q, idx_d;
  logic signed [KEY_WIDTH-1:0] skey_q, skey_d;

  logic                        out_valid_q;
  logic signed [KEY_WIDTH-1:0] out_key_q;
  logic [POS_W-1:0]            out_pos_q;
  status_e                     out_status_q;
  logic                        out_last_q;

  logic                        slot_free, emit, e_last;
  logic signed [KEY_WIDTH-1:0] e_key;
  logic [POS_W-1:0]            e_pos;
  status_e                     e_status;
  logic                        is_full, is_empty, walk_end;
  logic [PTR_W-1:0]            front_dec;
  logic [CNT_W-1:0]            idx_next;

  assign slot_free = !out_valid_q || out_o.ready;
  assign is_full   = (count_q == CNT_W'(DEPTH));
  assign is_empty  = (count_q == '0);
  assign front_dec = (front_q == '0) ? PTR_W'(DEPTH - 1) : front_q - 1'b1;
  assign idx_next  = idx_q + 1'b1;
  assign walk_end  = (idx_next == count_q);

  // Sequencer: one command at a time, walks read one entry per cycle while the result register is free.
  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    count_d     = count_q;
    idx_d       = idx_q;
    skey_d      = skey_q;
    cmd_ready_o = 1'b0;
    we          = 1'b0;
    waddr       = front_q;
    re          = 1'b0;
    raddr       = front_q;
    emit        = 1'b0;
    e_key       = '0;
    e_pos       = '0;
    e_status    = ST_OK;
    e_last      = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && slot_free) begin
          cmd_ready_o = 1'b1;
          case (cmd_i.op)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
              emit = 1'b1;
              if (is_full) begin
                e_status = ST_FULL;
              end else begin
                we      = 1'b1;
                count_d = count_q + 1'b1;
                if (cmd_i.op == MODE_PUSH_FRONT) begin
                  waddr   = front_dec;
                  front_d = front_dec;
                end else begin
                  waddr = ring_add(front_q, PTR_W'(count_q));
                end
              end
            end
            MODE_POP_BACK, MODE_POP_FRONT: begin
              if (is_empty) begin
                emit     = 1'b1;
                e_status = ST_EMPTY;
              end else begin
                re      = 1'b1;
                count_d = count_q - 1'b1;
                state_d = S_POP;
                if (cmd_i.op == MODE_POP_BACK) begin
                  raddr = ring_add(front_q, PTR_W'(count_q - 1'b1));
                  idx_d = count_q - 1'b1;
                end else begin
                  front_d = ring_add(front_q, PTR_W'(1));
                  idx_d   = '0;
                end
              end
            end
            MODE_SEARCH: begin
              if (is_empty) begin
                emit     = 1'b1;
                e_status = ST_NOT_FOUND;
              end else begin
                re      = 1'b1;
                idx_d   = '0;
                skey_d  = cmd_i.key;
                state_d = S_SEARCH;
              end
            end
            MODE_DUMP: begin
              if (is_empty) begin
                emit     = 1'b1;
                e_status = ST_EMPTY;
              end else begin
                re      = 1'b1;
                idx_d   = '0;
                state_d = S_DUMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        if (slot_free) begin
          emit    = 1'b1;
          e_key   = rdata_q;
          e_pos   = pos_of(idx_q);
          state_d = S_IDLE;
        end
      end
      S_SEARCH: begin
        if (slot_free) begin
          if (rdata_q == skey_q) begin
            emit    = 1'b1;
            e_pos   = pos_of(idx_q);
            state_d = S_IDLE;
          end else if (walk_end) begin
            emit     = 1'b1;
            e_status = ST_NOT_FOUND;
            state_d  = S_IDLE;
          end else begin
            re    = 1'b1;
            raddr = ring_add(front_q, PTR_W'(idx_next));
            idx_d = idx_next;
          end
        end
      end
      S_DUMP: begin
        if (slot_free) begin
          emit   = 1'b1;
          e_key  = rdata_q;
          e_pos  = pos_of(idx_q);
          e_last = walk_end;
          if (walk_end) begin
            state_d = S_IDLE;
          end else begin
            re    = 1'b1;
            raddr = ring_add(front_q, PTR_W'(idx_next));
            idx_d = idx_next;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    skey_q <= skey_d;
    if (emit) begin
      out_key_q    <= e_key;
      out_pos_q    <= e_pos;
      out_status_q <= e_status;
      out_last_q   <= e_last;
    end
  end

  // Memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= cmd_i.key;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.key_out  = out_key_q;
  assign out_o.position = out_pos_q;
  assign out_o.status   = out_status_q;
  assign out_o.last     = out_last_q;

  // The entry count never passes the ring size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count exceeds ring size");

  // A walk only visits stored entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH || state_q == S_DUMP) |-> (idx_q < count_q))
    else $error("walk index beyond stored entries");

  // A result is never loaded over one that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || out_o.ready))
    else $error("result register overwritten");

  // A pop never starts from an empty ring and leaves one entry fewer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && state_d == S_POP) |=> (count_q == $past(count_q) - 1'b1))
    else $error("pop did not remove one entry");

endmodule

>>> rtl/bounded_deque_with_search.sv
// ----------------------------------------------------------------------------
// Bounded deque with search
// Ring of signed keys with push and pop at both ends, search and dump.
// ----------------------------------------------------------------------------
// The front end takes one item per cycle into a two-entry command queue while
// the queue has room, and drops unused mode codes at once. The back end carries
// out one command at a time: a push writes the ring as it is taken, a pop goes
// through one registered memory read, and a search or a dump reads the entries
// it visits one by one through the single read port of the key memory. A dump
// sends one result per stored key; every other command sends one result. The
// back end loads a new result, and starts the next command, only when the
// result register is empty or its result is taken in that same cycle, so a
// result side that holds off stalls the back end.
module bounded_deque_with_search
  import bdq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  bdq_in_if.sink    in_i,
  bdq_out_if.source out_o
);

  logic front_valid, front_ready;
  cmd_t front_cmd;
  logic back_valid, back_ready;
  cmd_t back_cmd;

  bdq_front u_front (
    .in_i        (in_i),
    .cmd_valid_o (front_valid),
    .cmd_o       (front_cmd),
    .cmd_ready_i (front_ready)
  );

  bdq_cmd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_cmd_i    (front_cmd),
    .in_ready_o  (front_ready),
    .out_valid_o (back_valid),
    .out_cmd_o   (back_cmd),
    .out_ready_i (back_ready)
  );

  bdq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (back_valid),
    .cmd_i       (back_cmd),
    .cmd_ready_o (back_ready),
    .out_o       (out_o)
  );

endmodule
